FILE: rtl/euler_zyz_rotation_matrix_macros.svh
// assertion macros for the euler zyz rotation matrix block
`ifndef EULER_ZYZ_ROTATION_MATRIX_MACROS_SVH
`define EULER_ZYZ_ROTATION_MATRIX_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define EZR_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define EZR_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/ezr_pkg.sv
// shared constants and types for the euler zyz rotation matrix block
package ezr_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int ENTRY_BITS = 16;
  localparam int ANGLE_SHIFT = 32 - ANGLE_BITS;
  localparam int ENTRY_SHIFT = 32 - ENTRY_BITS;

  localparam int LANES = 3;
  localparam int ITERS = 30;
  localparam int QW = 32;
  localparam int XW = 34;
  localparam int ZW = 33;

  localparam logic signed [XW-1:0] CORDIC_X0 = 34'sd652032874;

  localparam logic [31:0] ATAN_TAB [ITERS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef struct packed {
    logic signed [QW-1:0] cos_val;
    logic signed [QW-1:0] sin_val;
  } trig_t;

  typedef struct packed {
    logic signed [ENTRY_BITS-1:0] m00;
    logic signed [ENTRY_BITS-1:0] m01;
    logic signed [ENTRY_BITS-1:0] m02;
    logic signed [ENTRY_BITS-1:0] m10;
    logic signed [ENTRY_BITS-1:0] m11;
    logic signed [ENTRY_BITS-1:0] m12;
    logic signed [ENTRY_BITS-1:0] m20;
    logic signed [ENTRY_BITS-1:0] m21;
    logic signed [ENTRY_BITS-1:0] m22;
  } mat_t;

endpackage

FILE: rtl/ezr_if.sv
// valid/ready channel interfaces for angle triples and matrix words
interface ezr_angle_if;
  logic valid;
  logic ready;
  logic signed [ezr_pkg::ANGLE_BITS-1:0] angle_first;
  logic signed [ezr_pkg::ANGLE_BITS-1:0] angle_second;
  logic signed [ezr_pkg::ANGLE_BITS-1:0] angle_third;

  modport source (output valid, output angle_first, output angle_second,
                  output angle_third, input ready);
  modport sink (input valid, input angle_first, input angle_second,
                input angle_third, output ready);
endinterface

interface ezr_matrix_if;
  logic valid;
  logic ready;
  logic signed [ezr_pkg::ENTRY_BITS-1:0] m00;
  logic signed [ezr_pkg::ENTRY_BITS-1:0] m01;
  logic signed [ezr_pkg::ENTRY_BITS-1:0] m02;
  logic signed [ezr_pkg::ENTRY_BITS-1:0] m10;
  logic signed [ezr_pkg::ENTRY_BITS-1:0] m11;
  logic signed [ezr_pkg::ENTRY_BITS-1:0] m12;
  logic signed [ezr_pkg::ENTRY_BITS-1:0] m20;
  logic signed [ezr_pkg::ENTRY_BITS-1:0] m21;
  logic signed [ezr_pkg::ENTRY_BITS-1:0] m22;

  modport source (output valid, output m00, output m01, output m02, output m10,
                  output m11, output m12, output m20, output m21, output m22,
                  input ready);
  modport sink (input valid, input m00, input m01, input m02, input m10,
                input m11, input m12, input m20, input m21, input m22,
                output ready);
endinterface

FILE: rtl/ezr_cordic.sv
// pipelined cordic rotator, one iteration per stage, three angle lanes
module ezr_cordic (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [ezr_pkg::ANGLE_BITS-1:0]  angle_i [ezr_pkg::LANES],
  output logic                            valid_o,
  output ezr_pkg::trig_t                  trig_o [ezr_pkg::LANES]
);

  localparam int LANES = ezr_pkg::LANES;
  localparam int ITERS = ezr_pkg::ITERS;
  localparam int XW = ezr_pkg::XW;
  localparam int ZW = ezr_pkg::ZW;
  localparam int QW = ezr_pkg::QW;
  localparam logic signed [ZW-1:0] Q_QUARTER = 33'sd1073741824;
  localparam logic signed [ZW-1:0] Q_HALF = 33'sd2147483648;

  logic [ITERS+1:0]      valid_q;
  logic signed [XW-1:0]  x_q    [LANES][ITERS+1];
  logic signed [XW-1:0]  y_q    [LANES][ITERS+1];
  logic signed [ZW-1:0]  z_q    [LANES][ITERS+1];
  logic                  flip_q [LANES][ITERS+1];
  ezr_pkg::trig_t        trig_q [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[ITERS:0], valid_i};
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [31:0]   a32;
    logic signed [ZW-1:0] z_in;
    logic signed [ZW-1:0] z_pre;
    logic                 flip_d;

    // fold the angle into the right half plane, negate the result later
    always_comb begin
      a32 = signed'(32'(angle_i[l]) << ezr_pkg::ANGLE_SHIFT);
      z_in = ZW'(a32);
      z_pre = z_in;
      flip_d = 1'b0;
      if (z_in > Q_QUARTER) begin
        z_pre = z_in - Q_HALF;
        flip_d = 1'b1;
      end else if (z_in < -Q_QUARTER) begin
        z_pre = z_in + Q_HALF;
        flip_d = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[l][0]    <= ezr_pkg::CORDIC_X0;
        y_q[l][0]    <= '0;
        z_q[l][0]    <= z_pre;
        flip_q[l][0] <= flip_d;
      end
    end

    for (genvar i = 0; i < ITERS; i++) begin : g_iter
      localparam logic signed [ZW-1:0] ATAN_I = ZW'(ezr_pkg::ATAN_TAB[i]);
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;

      assign dx = y_q[l][i] >>> i;
      assign dy = x_q[l][i] >>> i;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!z_q[l][i][ZW-1]) begin
            x_q[l][i+1] <= x_q[l][i] - dx;
            y_q[l][i+1] <= y_q[l][i] + dy;
            z_q[l][i+1] <= z_q[l][i] - ATAN_I;
          end else begin
            x_q[l][i+1] <= x_q[l][i] + dx;
            y_q[l][i+1] <= y_q[l][i] - dy;
            z_q[l][i+1] <= z_q[l][i] + ATAN_I;
          end
          flip_q[l][i+1] <= flip_q[l][i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (flip_q[l][ITERS]) begin
          trig_q[l].cos_val <= QW'(-x_q[l][ITERS]);
          trig_q[l].sin_val <= QW'(-y_q[l][ITERS]);
        end else begin
          trig_q[l].cos_val <= QW'(x_q[l][ITERS]);
          trig_q[l].sin_val <= QW'(y_q[l][ITERS]);
        end
      end
    end

    assign trig_o[l] = trig_q[l];
  end

  assign valid_o = valid_q[ITERS+1];

endmodule

FILE: rtl/euler_zyz_rotation_matrix.sv
// z-y-z euler angles to rotation matrix, pipelined cordic and product datapath
//
// ang_i carries one word per angle triple (first z, y, second z), each a
// signed binary angle where full scale is plus or minus pi. mat_o carries the
// nine matrix entries, row-major, as signed Q2.14 saturated to +/-1.0.
// Both channels move a word when valid and ready are high at a clock edge.
// From acceptance to mat_o.valid a word passes one fold stage, 30 cordic
// iteration stages, one sign fix stage, two multiply stages, one sum and
// rounding stage and the output register.
// Throughput is one word per cycle while the skid register stays empty; the
// three cordic lanes and the product stages are all fully pipelined.
// The whole pipe advances together while the skid register is empty, and
// ang_i.ready comes straight from that register. When the receiver stalls,
// the output register holds its word, the next finished word goes to the
// skid register, and only then does ang_i.ready drop; nothing is lost.
// Reset (rst_ni low, asynchronous) empties all valid bits and both output
// registers; ang_i.ready is high after reset.
module euler_zyz_rotation_matrix (
  input  logic         clk_i,
  input  logic         rst_ni,
  ezr_angle_if.sink    ang_i,
  ezr_matrix_if.source mat_o
);

  localparam int LANES = ezr_pkg::LANES;
  localparam int AB = ezr_pkg::ANGLE_BITS;
  localparam int EB = ezr_pkg::ENTRY_BITS;
  localparam int QW = ezr_pkg::QW;
  localparam int SW = QW + 2;
  localparam int SHIFT = ezr_pkg::ENTRY_SHIFT;
  localparam logic signed [SW-1:0] RND =
    (SHIFT > 0) ? SW'(64'sd1 <<< (SHIFT - 1)) : '0;
  localparam logic signed [SW-1:0] ONE = SW'(64'sd1 <<< (EB - 2));
  localparam logic signed [2*QW-1:0] Q_HALF_LSB = 64'sd536870912;

  // q30 product, halves round up
  function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b + Q_HALF_LSB;
    return QW'(p >>> 30);
  endfunction

  function automatic logic signed [EB-1:0] to_entry(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + RND) >>> SHIFT;
    if (r > ONE) r = ONE;
    if (r < -ONE) r = -ONE;
    return EB'(r);
  endfunction

  logic                 adv;
  logic [AB-1:0]        angles [LANES];
  logic                 cor_valid;
  ezr_pkg::trig_t       trig [LANES];

  logic                 v1_q, v2_q, v3_q;
  logic signed [QW-1:0] cacb_q, sacb_q, sasc_q, casc_q, sbcc_q;
  logic signed [QW-1:0] sacc_q, cacc_q, sbsc_q, casb_q, sasb_q;
  logic signed [QW-1:0] cc_q, sc_q, cb_q;
  logic signed [QW-1:0] t00_q, t01_q, t10_q, t11_q;
  logic signed [QW-1:0] sasc2_q, casc2_q, sbcc2_q, sacc2_q, cacc2_q;
  logic signed [QW-1:0] sbsc2_q, casb2_q, sasb2_q, cb2_q;
  ezr_pkg::mat_t        mat_d, mat_q;
  ezr_pkg::mat_t        out_q, skid_q;
  logic                 out_valid_q, skid_valid_q;
  logic                 take;

  assign adv = !skid_valid_q;
  assign ang_i.ready = adv;

  assign angles[0] = ang_i.angle_first;
  assign angles[1] = ang_i.angle_second;
  assign angles[2] = ang_i.angle_third;

  ezr_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (ang_i.valid),
    .angle_i (angles),
    .valid_o (cor_valid),
    .trig_o  (trig)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= cor_valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // two-factor products and single factors passed on; lane 0 is a, lane 1 is b, lane 2 is c
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cacb_q <= qmul(trig[0].cos_val, trig[1].cos_val);
      sacb_q <= qmul(trig[0].sin_val, trig[1].cos_val);
      sasc_q <= qmul(trig[0].sin_val, trig[2].sin_val);
      casc_q <= qmul(trig[0].cos_val, trig[2].sin_val);
      sbcc_q <= qmul(trig[1].sin_val, trig[2].cos_val);
      sacc_q <= qmul(trig[0].sin_val, trig[2].cos_val);
      cacc_q <= qmul(trig[0].cos_val, trig[2].cos_val);
      sbsc_q <= qmul(trig[1].sin_val, trig[2].sin_val);
      casb_q <= qmul(trig[0].cos_val, trig[1].sin_val);
      sasb_q <= qmul(trig[0].sin_val, trig[1].sin_val);
      cc_q   <= trig[2].cos_val;
      sc_q   <= trig[2].sin_val;
      cb_q   <= trig[1].cos_val;
    end
  end

  // third factor of the triple products, the other terms delayed alongside
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t00_q   <= qmul(cacb_q, cc_q);
      t01_q   <= qmul(sacb_q, cc_q);
      t10_q   <= qmul(cacb_q, sc_q);
      t11_q   <= qmul(sacb_q, sc_q);
      sasc2_q <= sasc_q;
      casc2_q <= casc_q;
      sbcc2_q <= sbcc_q;
      sacc2_q <= sacc_q;
      cacc2_q <= cacc_q;
      sbsc2_q <= sbsc_q;
      casb2_q <= casb_q;
      sasb2_q <= sasb_q;
      cb2_q   <= cb_q;
    end
  end

  always_comb begin
    mat_d.m00 = to_entry(SW'(t00_q) - SW'(sasc2_q));
    mat_d.m01 = to_entry(-SW'(t01_q) - SW'(casc2_q));
    mat_d.m02 = to_entry(-SW'(sbcc2_q));
    mat_d.m10 = to_entry(SW'(t10_q) + SW'(sacc2_q));
    mat_d.m11 = to_entry(-SW'(t11_q) + SW'(cacc2_q));
    mat_d.m12 = to_entry(-SW'(sbsc2_q));
    mat_d.m20 = to_entry(SW'(casb2_q));
    mat_d.m21 = to_entry(-SW'(sasb2_q));
    mat_d.m22 = to_entry(SW'(cb2_q));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mat_q <= mat_d;
    end
  end

  // output register with a skid stage behind it
  assign take = out_valid_q && mat_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= v3_q;
      end
    end else if (v3_q && adv) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_q <= skid_valid_q ? skid_q : mat_q;
    end else if (v3_q && adv) begin
      skid_q <= mat_q;
    end
  end

  assign mat_o.valid = out_valid_q;
  assign mat_o.m00 = out_q.m00;
  assign mat_o.m01 = out_q.m01;
  assign mat_o.m02 = out_q.m02;
  assign mat_o.m10 = out_q.m10;
  assign mat_o.m11 = out_q.m11;
  assign mat_o.m12 = out_q.m12;
  assign mat_o.m20 = out_q.m20;
  assign mat_o.m21 = out_q.m21;
  assign mat_o.m22 = out_q.m22;

endmodule

FILE: rtl/ezr_checker.sv
// port-level assertions for the euler zyz rotation matrix block, with bind
`include "euler_zyz_rotation_matrix_macros.svh"

module ezr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [9*ezr_pkg::ENTRY_BITS-1:0]  out_data_i
);

  logic                             stall;
  logic                             full_taken;
  logic                             reopened;
  logic [9*ezr_pkg::ENTRY_BITS:0]   out_word;

  assign stall      = out_valid_i && !out_ready_i;
  assign full_taken = !in_ready_i && out_ready_i;
  assign reopened   = in_ready_i && out_valid_i;
  assign out_word   = {out_valid_i, out_data_i};

  // a word waiting on mat_o stays put until taken
  `EZR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stall, $stable(out_word), "word not held")

  // with nothing waiting at the output there is no back pressure
  `EZR_ASSERT_NOW(a_idle_ready, clk_i, rst_ni, !out_valid_i, in_ready_i, "ready low while idle")

  // back pressure only follows a stalled output word
  `EZR_ASSERT_NOW(a_stall_src, clk_i, rst_ni, $fell(in_ready_i), $past(stall), "stray back pressure")

  // once the held word is taken the skid word moves up and input reopens
  `EZR_ASSERT_NEXT(a_full_drains, clk_i, rst_ni, full_taken, reopened, "skid word not drained")

endmodule

bind euler_zyz_rotation_matrix ezr_checker u_ezr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (ang_i.ready),
  .out_valid_i (mat_o.valid),
  .out_ready_i (mat_o.ready),
  .out_data_i  ({mat_o.m00, mat_o.m01, mat_o.m02, mat_o.m10, mat_o.m11,
                 mat_o.m12, mat_o.m20, mat_o.m21, mat_o.m22})
);
